>>> design/charger_fault_qualifier_defines.svh
// Assertion helpers shared by the fault qualifier RTL.
`ifndef CHARGER_FAULT_QUALIFIER_DEFINES_SVH
`define CHARGER_FAULT_QUALIFIER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check on the local clk, off while rst is high.
`define CFQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check with an explicit clock and reset.
`define CFQ_ASSERT_ON(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`else
`define CFQ_ASSERT(lbl, prop, msg)
`define CFQ_ASSERT_ON(lbl, ck, rs, prop, msg)
`endif
`endif

>>> design/cfq_pkg.sv
package cfq_pkg;

  localparam int LEVEL_W   = 16;
  localparam int CFG_IDX_W = 4;
  localparam int DEB_W     = 8;

  // Debounce and presence thresholds
  localparam logic [DEB_W-1:0]   DEBOUNCE_LIMIT = 8'd10;
  localparam logic [LEVEL_W-1:0] GUN_LEVEL      = 16'd2048;
  localparam logic [LEVEL_W-1:0] VEHICLE_LEVEL  = 16'd1024;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OC_TRIP   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OC_CLEAR  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UV_TRIP   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UV_CLEAR  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OV_TRIP   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OV_CLEAR  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK_TRIP = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST   = 4'd7;

  // Register reset values
  localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 16'hFFFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN     = 16'h0000;
  localparam logic [LEVEL_W-1:0] PERSIST_RESET = 16'd10;

  typedef struct packed {
    logic [LEVEL_W-1:0] oc_trip_level;
    logic [LEVEL_W-1:0] oc_clear_level;
    logic [LEVEL_W-1:0] uv_trip_level;
    logic [LEVEL_W-1:0] uv_clear_level;
    logic [LEVEL_W-1:0] ov_trip_level;
    logic [LEVEL_W-1:0] ov_clear_level;
    logic [LEVEL_W-1:0] leak_trip_level;
    logic [LEVEL_W-1:0] persist_ticks;
  } cfg_t;

  // Per-tick qualifier request
  typedef struct packed {
    logic en;
    logic trip;
    logic clr;
  } qual_req_t;

endpackage

>>> design/cfq_cfg.sv
module cfq_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfq_pkg::LEVEL_W-1:0]   cfg_data,
  output cfq_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  // Decode a register write; drop indexes past the list
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.oc_trip_level   <= cfq_pkg::LEVEL_MAX;
      cfg.oc_clear_level  <= cfq_pkg::LEVEL_MAX;
      cfg.uv_trip_level   <= cfq_pkg::LEVEL_MIN;
      cfg.uv_clear_level  <= cfq_pkg::LEVEL_MIN;
      cfg.ov_trip_level   <= cfq_pkg::LEVEL_MAX;
      cfg.ov_clear_level  <= cfq_pkg::LEVEL_MAX;
      cfg.leak_trip_level <= cfq_pkg::LEVEL_MAX;
      cfg.persist_ticks   <= cfq_pkg::PERSIST_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cfq_pkg::REG_OC_TRIP:   cfg.oc_trip_level   <= cfg_data;
        cfq_pkg::REG_OC_CLEAR:  cfg.oc_clear_level  <= cfg_data;
        cfq_pkg::REG_UV_TRIP:   cfg.uv_trip_level   <= cfg_data;
        cfq_pkg::REG_UV_CLEAR:  cfg.uv_clear_level  <= cfg_data;
        cfq_pkg::REG_OV_TRIP:   cfg.ov_trip_level   <= cfg_data;
        cfq_pkg::REG_OV_CLEAR:  cfg.ov_clear_level  <= cfg_data;
        cfq_pkg::REG_LEAK_TRIP: cfg.leak_trip_level <= cfg_data;
        cfq_pkg::REG_PERSIST:   cfg.persist_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> design/cfq_qualifier.sv
`include "charger_fault_qualifier_defines.svh"

module cfq_qualifier (
  input  logic                        clk,
  input  logic                        rst,
  input  cfq_pkg::qual_req_t          req,
  input  logic [cfq_pkg::LEVEL_W-1:0] persist_ticks,
  output logic                        flag
);

  logic [cfq_pkg::LEVEL_W-1:0] trip_count, trip_count_next;
  logic [cfq_pkg::LEVEL_W-1:0] clear_count, clear_count_next;
  logic                        flag_next;

  // Count toward trip or clear; trip wins when both hold, hold inside the band
  always_comb begin
    trip_count_next  = trip_count;
    clear_count_next = clear_count;
    flag_next        = flag;
    if (req.trip) begin
      clear_count_next = '0;
      trip_count_next  = (trip_count == cfq_pkg::LEVEL_MAX) ? trip_count
                                                             : trip_count + 1'b1;
      if (trip_count_next >= persist_ticks) flag_next = 1'b1;
    end else if (req.clr) begin
      trip_count_next  = '0;
      clear_count_next = (clear_count == cfq_pkg::LEVEL_MAX) ? clear_count
                                                              : clear_count + 1'b1;
      if (clear_count_next >= persist_ticks) flag_next = 1'b0;
    end
  end

  // Advance only when a tick moves into the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      trip_count  <= '0;
      clear_count <= '0;
      flag        <= 1'b0;
    end else if (req.en) begin
      trip_count  <= trip_count_next;
      clear_count <= clear_count_next;
      flag        <= flag_next;
    end
  end

  `CFQ_ASSERT(a_one_count_live, !(trip_count != '0 && clear_count != '0), "both counts live")
  `CFQ_ASSERT(a_hold_when_idle, !req.en |=> $stable(flag) && $stable(trip_count), "idle change")

endmodule

>>> design/cfq_debounce.sv
`include "charger_fault_qualifier_defines.svh"

module cfq_debounce (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic cond,
  output logic flag
);

  logic [cfq_pkg::DEB_W-1:0] count, count_next;
  logic                      flag_next;

  // Ramp up to the limit while the condition holds, down to zero otherwise
  always_comb begin
    count_next = count;
    flag_next  = flag;
    if (cond) begin
      if (count >= cfq_pkg::DEBOUNCE_LIMIT) flag_next = 1'b1;
      else count_next = count + 1'b1;
    end else begin
      if (count != '0) count_next = count - 1'b1;
      else flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      flag  <= 1'b0;
    end else if (en) begin
      count <= count_next;
      flag  <= flag_next;
    end
  end

  `CFQ_ASSERT_ON(a_count_bound, clk, rst, count <= cfq_pkg::DEBOUNCE_LIMIT, "debounce overrun")

endmodule

>>> design/charger_fault_qualifier.sv
// Channel | Direction | Handshake             | Payload
// in      | in        | in_valid / in_ready   | load_current, line_voltage, leak_current,
//         |           |                       | pilot_sense, estop_pin
// out     | out       | out_valid / out_ready | seven fault and presence flags
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
// One tick per clock sustained while out_ready stays high; a tick's flags reach the outputs
// through the input register, which holds it after its transfer, and then the flag registers,
// which the counter update loads and which are the result register.
// The input register lets the next tick transfer while a result waits on out_ready;
// with both registers full and out_ready low, in_ready drops until the result transfers.
// rst (synchronous) clears counters and flags and loads the register reset values.
`include "charger_fault_qualifier_defines.svh"

module charger_fault_qualifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [15:0]                   load_current,
  input  logic [15:0]                   line_voltage,
  input  logic [15:0]                   leak_current,
  input  logic [15:0]                   pilot_sense,
  input  logic                          estop_pin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          overcurrent,
  output logic                          undervoltage,
  output logic                          overvoltage,
  output logic                          leakage_fault,
  output logic                          gun_present,
  output logic                          vehicle_present,
  output logic                          estop_active,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);

  cfq_pkg::cfg_t cfg;

  logic        pipe_valid;
  logic [15:0] cur, volt, leak, pilot;
  logic        estop;
  logic        advance;

  cfq_pkg::qual_req_t oc_req, uv_req, ov_req, leak_req;

  cfq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Move a tick into the result stage when the result slot is free or draining
  assign advance  = pipe_valid && (!out_valid || out_ready);
  assign in_ready = !pipe_valid || advance;

  // Hold the input tick
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (in_ready) begin
      pipe_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cur   <= load_current;
      volt  <= line_voltage;
      leak  <= leak_current;
      pilot <= pilot_sense;
      estop <= estop_pin;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Level compares
  assign oc_req   = '{en: advance, trip: cur > cfg.oc_trip_level,
                      clr: cur <= cfg.oc_clear_level};
  assign uv_req   = '{en: advance, trip: volt < cfg.uv_trip_level,
                      clr: volt >= cfg.uv_clear_level};
  assign ov_req   = '{en: advance, trip: volt > cfg.ov_trip_level,
                      clr: volt <= cfg.ov_clear_level};
  assign leak_req = '{en: advance, trip: leak > cfg.leak_trip_level, clr: 1'b1};

  cfq_qualifier u_oc (
    .clk (clk), .rst (rst), .req (oc_req),
    .persist_ticks (cfg.persist_ticks), .flag (overcurrent)
  );

  cfq_qualifier u_uv (
    .clk (clk), .rst (rst), .req (uv_req),
    .persist_ticks (cfg.persist_ticks), .flag (undervoltage)
  );

  cfq_qualifier u_ov (
    .clk (clk), .rst (rst), .req (ov_req),
    .persist_ticks (cfg.persist_ticks), .flag (overvoltage)
  );

  cfq_qualifier u_leak (
    .clk (clk), .rst (rst), .req (leak_req),
    .persist_ticks (cfg.persist_ticks), .flag (leakage_fault)
  );

  cfq_debounce u_gun (
    .clk (clk), .rst (rst), .en (advance),
    .cond (pilot < cfq_pkg::GUN_LEVEL), .flag (gun_present)
  );

  cfq_debounce u_veh (
    .clk (clk), .rst (rst), .en (advance),
    .cond (pilot < cfq_pkg::VEHICLE_LEVEL), .flag (vehicle_present)
  );

  cfq_debounce u_estop (
    .clk (clk), .rst (rst), .en (advance),
    .cond (estop), .flag (estop_active)
  );

  `CFQ_ASSERT(a_adv_gives_result, advance |=> out_valid, "tick lost")
  `CFQ_ASSERT(a_full_stalls_input, pipe_valid && out_valid && !out_ready |-> !in_ready, "overrun")
  `CFQ_ASSERT(a_flags_hold, !advance |=> $stable(overcurrent) && $stable(gun_present), "flag drift")

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  // Register indexes past the end of the map; writes there must be dropped
  localparam logic [cfq_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [cfq_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  typedef struct {
    logic [15:0] current;
    logic [15:0] voltage;
    logic [15:0] leakage;
    logic [15:0] pilot;
    logic        estop;
  } tick_t;

  typedef struct packed {
    logic oc;
    logic uv;
    logic ov;
    logic leak;
    logic gun;
    logic veh;
    logic estop;
  } fault_flags_t;

  // Where a stimulus run places a sample relative to the configured levels
  typedef enum int {MODE_TRIP, MODE_BAND, MODE_CLEAR, MODE_ANY} level_mode_t;

  // Fault flag predictor plus the queue of flag sets still owed by the block
  class flag_scoreboard;
    cfq_pkg::cfg_t cfg;
    logic [15:0]   oc_trip_cnt, oc_clear_cnt, uv_trip_cnt, uv_clear_cnt;
    logic [15:0]   ov_trip_cnt, ov_clear_cnt, leak_trip_cnt, leak_clear_cnt;
    logic [7:0]    gun_cnt, veh_cnt, estop_cnt;
    fault_flags_t  flags;
    fault_flags_t  expected_q[$];
    int            mismatches;
    int            checked;

    function new();
      cfg.oc_trip_level   = cfq_pkg::LEVEL_MAX;
      cfg.oc_clear_level  = cfq_pkg::LEVEL_MAX;
      cfg.uv_trip_level   = cfq_pkg::LEVEL_MIN;
      cfg.uv_clear_level  = cfq_pkg::LEVEL_MIN;
      cfg.ov_trip_level   = cfq_pkg::LEVEL_MAX;
      cfg.ov_clear_level  = cfq_pkg::LEVEL_MAX;
      cfg.leak_trip_level = cfq_pkg::LEVEL_MAX;
      cfg.persist_ticks   = cfq_pkg::PERSIST_RESET;
      {oc_trip_cnt, oc_clear_cnt, uv_trip_cnt, uv_clear_cnt} = '0;
      {ov_trip_cnt, ov_clear_cnt, leak_trip_cnt, leak_clear_cnt} = '0;
      {gun_cnt, veh_cnt, estop_cnt} = '0;
      flags      = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [cfq_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        cfq_pkg::REG_OC_TRIP:   cfg.oc_trip_level   = val;
        cfq_pkg::REG_OC_CLEAR:  cfg.oc_clear_level  = val;
        cfq_pkg::REG_UV_TRIP:   cfg.uv_trip_level   = val;
        cfq_pkg::REG_UV_CLEAR:  cfg.uv_clear_level  = val;
        cfq_pkg::REG_OV_TRIP:   cfg.ov_trip_level   = val;
        cfq_pkg::REG_OV_CLEAR:  cfg.ov_clear_level  = val;
        cfq_pkg::REG_LEAK_TRIP: cfg.leak_trip_level = val;
        cfq_pkg::REG_PERSIST:   cfg.persist_ticks   = val;
        default: ;
      endcase
    endfunction

    // Trip wins over clear; counters saturate at all ones
    function void qualify(bit trip, bit clr, inout logic [15:0] tc,
                          inout logic [15:0] cc, inout logic flag);
      if (trip) begin
        cc = '0;
        if (tc != cfq_pkg::LEVEL_MAX) tc = tc + 16'd1;
        if (tc >= cfg.persist_ticks) flag = 1'b1;
      end else if (clr) begin
        tc = '0;
        if (cc != cfq_pkg::LEVEL_MAX) cc = cc + 16'd1;
        if (cc >= cfg.persist_ticks) flag = 1'b0;
      end
    endfunction

    // Up/down counter: flag moves only when the counter is already pinned
    function void debounce(bit cond, inout logic [7:0] cnt, inout logic flag);
      if (cond) begin
        if (cnt >= cfq_pkg::DEBOUNCE_LIMIT) flag = 1'b1;
        else cnt = cnt + 8'd1;
      end else begin
        if (cnt != 8'd0) cnt = cnt - 8'd1;
        else flag = 1'b0;
      end
    endfunction

    function void note_tick(tick_t t);
      qualify(t.current > cfg.oc_trip_level, t.current <= cfg.oc_clear_level,
              oc_trip_cnt, oc_clear_cnt, flags.oc);
      qualify(t.voltage < cfg.uv_trip_level, t.voltage >= cfg.uv_clear_level,
              uv_trip_cnt, uv_clear_cnt, flags.uv);
      qualify(t.voltage > cfg.ov_trip_level, t.voltage <= cfg.ov_clear_level,
              ov_trip_cnt, ov_clear_cnt, flags.ov);
      qualify(t.leakage > cfg.leak_trip_level, 1'b1,
              leak_trip_cnt, leak_clear_cnt, flags.leak);
      debounce(t.pilot < cfq_pkg::GUN_LEVEL, gun_cnt, flags.gun);
      debounce(t.pilot < cfq_pkg::VEHICLE_LEVEL, veh_cnt, flags.veh);
      debounce(t.estop == 1'b1, estop_cnt, flags.estop);
      expected_q.push_back(flags);
    endfunction

    function void check_flags(fault_flags_t got);
      fault_flags_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: got flags %b with nothing outstanding", checked, got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected flags %b, got %b (oc uv ov leak gun veh estop)",
                   checked, want, got);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [15:0]                   load_current;
  logic [15:0]                   line_voltage;
  logic [15:0]                   leak_current;
  logic [15:0]                   pilot_sense;
  logic                          estop_pin;
  logic                          out_valid;
  logic                          out_ready;
  logic                          overcurrent;
  logic                          undervoltage;
  logic                          overvoltage;
  logic                          leakage_fault;
  logic                          gun_present;
  logic                          vehicle_present;
  logic                          estop_active;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [cfq_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                   cfg_data;

  flag_scoreboard sb;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  bit stall_req    = 1'b0;
  int stall_count  = 0;
  int quiet_cycles = 0;

  charger_fault_qualifier u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .load_current    (load_current),
    .line_voltage    (line_voltage),
    .leak_current    (leak_current),
    .pilot_sense     (pilot_sense),
    .estop_pin       (estop_pin),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .overcurrent     (overcurrent),
    .undervoltage    (undervoltage),
    .overvoltage     (overvoltage),
    .leakage_fault   (leakage_fault),
    .gun_present     (gun_present),
    .vehicle_present (vehicle_present),
    .estop_active    (estop_active),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic tick_t tick_of(logic [15:0] cur, logic [15:0] volt,
                                    logic [15:0] leak, logic [15:0] pilot,
                                    logic estop);
    tick_t t;
    t.current = cur;
    t.voltage = volt;
    t.leakage = leak;
    t.pilot   = pilot;
    t.estop   = estop;
    return t;
  endfunction

  // Uniform pick in [lo, hi]; fall back to any value when the range is empty
  function automatic logic [15:0] pick_between(int lo, int hi);
    if (lo > hi) return 16'($urandom);
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic [15:0] rand_level();
    case ($urandom_range(9))
      0:       return cfq_pkg::LEVEL_MIN;
      1:       return cfq_pkg::LEVEL_MAX;
      2, 3, 4: return 16'($urandom_range(4000));
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one tick and hold it until the transfer
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    load_current <= t.current;
    line_voltage <= t.voltage;
    leak_current <= t.leakage;
    pilot_sense  <= t.pilot;
    estop_pin    <= t.estop;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted flag set has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic program_reg(input logic [cfq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic program_all(input cfq_pkg::cfg_t c);
    program_reg(cfq_pkg::REG_OC_TRIP,   c.oc_trip_level);
    program_reg(cfq_pkg::REG_OC_CLEAR,  c.oc_clear_level);
    program_reg(cfq_pkg::REG_UV_TRIP,   c.uv_trip_level);
    program_reg(cfq_pkg::REG_UV_CLEAR,  c.uv_clear_level);
    program_reg(cfq_pkg::REG_OV_TRIP,   c.ov_trip_level);
    program_reg(cfq_pkg::REG_OV_CLEAR,  c.ov_clear_level);
    program_reg(cfq_pkg::REG_LEAK_TRIP, c.leak_trip_level);
    program_reg(cfq_pkg::REG_PERSIST,   c.persist_ticks);
  endtask

  // Runs of ticks that sit in one region per channel, with some pure noise mixed in
  task automatic send_random_ticks(input int count);
    int          sent;
    int          run_len;
    level_mode_t cur_mode, volt_mode, leak_mode, pilot_mode;
    bit          watch_uv;
    logic        estop_level;
    tick_t       t;
    sent = 0;
    while (sent < count) begin
      run_len     = $urandom_range(16, 1);
      cur_mode    = level_mode_t'($urandom_range(3));
      volt_mode   = level_mode_t'($urandom_range(3));
      leak_mode   = level_mode_t'($urandom_range(3));
      pilot_mode  = level_mode_t'($urandom_range(3));
      watch_uv    = 1'($urandom_range(1));
      estop_level = 1'($urandom_range(1));
      for (int i = 0; i < run_len && sent < count; i++) begin
        t = tick_of(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    1'($urandom_range(1)));
        if ($urandom_range(9) != 0) begin
          case (cur_mode)
            MODE_TRIP:  t.current = pick_between(int'(sb.cfg.oc_trip_level) + 1, 65535);
            MODE_BAND:  t.current = pick_between(int'(sb.cfg.oc_clear_level) + 1,
                                                 int'(sb.cfg.oc_trip_level));
            MODE_CLEAR: t.current = pick_between(0, int'(sb.cfg.oc_clear_level));
            default: ;
          endcase
          case (volt_mode)
            MODE_TRIP:
              t.voltage = watch_uv ? pick_between(0, int'(sb.cfg.uv_trip_level) - 1)
                                   : pick_between(int'(sb.cfg.ov_trip_level) + 1, 65535);
            MODE_BAND:
              t.voltage = watch_uv ? pick_between(int'(sb.cfg.uv_trip_level),
                                                  int'(sb.cfg.uv_clear_level) - 1)
                                   : pick_between(int'(sb.cfg.ov_clear_level) + 1,
                                                  int'(sb.cfg.ov_trip_level));
            MODE_CLEAR:
              t.voltage = pick_between(int'(sb.cfg.uv_clear_level),
                                       int'(sb.cfg.ov_clear_level));
            default: ;
          endcase
          case (leak_mode)
            MODE_TRIP:  t.leakage = pick_between(int'(sb.cfg.leak_trip_level) + 1, 65535);
            MODE_CLEAR: t.leakage = pick_between(0, int'(sb.cfg.leak_trip_level));
            default: ;
          endcase
          case (pilot_mode)
            MODE_TRIP:  t.pilot = pick_between(0, int'(cfq_pkg::VEHICLE_LEVEL) - 1);
            MODE_BAND:  t.pilot = pick_between(int'(cfq_pkg::VEHICLE_LEVEL),
                                               int'(cfq_pkg::GUN_LEVEL) - 1);
            MODE_CLEAR: t.pilot = pick_between(int'(cfq_pkg::GUN_LEVEL), 65535);
            default: ;
          endcase
          t.estop = estop_level;
        end
        send_tick(t);
        sent++;
      end
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req && stall_count < STALL_CYCLES) begin
        out_ready <= 1'b0;
        stall_count++;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Record input transfers before checking output transfers of the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.note_tick(tick_of(load_current, line_voltage, leak_current, pilot_sense,
                             estop_pin));
      if (out_valid && out_ready)
        sb.check_flags({overcurrent, undervoltage, overvoltage, leakage_fault,
                        gun_present, vehicle_present, estop_active});
    end
  end

  // End the run when no channel has moved a transfer for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfq_pkg::cfg_t c;
    int            phase;
    int            k;
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    load_current = '0;
    line_voltage = '0;
    leak_current = '0;
    pilot_sense  = '0;
    estop_pin    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Hysteresis bands with short persistence; unmapped indexes must not land
    c = '{oc_trip_level: 16'd1000, oc_clear_level: 16'd800,
          uv_trip_level: 16'd200,  uv_clear_level: 16'd300,
          ov_trip_level: 16'd5000, ov_clear_level: 16'd4000,
          leak_trip_level: 16'd30, persist_ticks: 16'd2};
    program_all(c);
    program_reg(REG_UNUSED_LO, cfq_pkg::LEVEL_MAX);
    program_reg(REG_UNUSED_HI, cfq_pkg::LEVEL_MIN);

    // Sustain extremes long enough to set every fault but overvoltage, and every debounced flag
    repeat (12) send_tick(tick_of(cfq_pkg::LEVEL_MAX, cfq_pkg::LEVEL_MIN,
                                  cfq_pkg::LEVEL_MAX, cfq_pkg::LEVEL_MIN, 1'b1));
    // Walk each compare across its level, and pilot across both presence levels
    send_tick(tick_of(16'd1000, 16'd200,  16'd30, 16'd1023, 1'b1));
    send_tick(tick_of(16'd1001, 16'd199,  16'd31, 16'd1024, 1'b0));
    send_tick(tick_of(16'd800,  16'd300,  16'd0,  16'd2047, 1'b0));
    send_tick(tick_of(16'd800,  16'd4001, 16'd0,  16'd2048, 1'b0));
    send_tick(tick_of(16'd0,    16'd5001, 16'd0,  cfq_pkg::LEVEL_MAX, 1'b0));
    send_tick(tick_of(16'd0,    16'd5000, 16'd0,  cfq_pkg::LEVEL_MAX, 1'b0));
    drain_results();

    // Overlapping levels so trip must win, with zero persistence
    c = '{oc_trip_level: 16'd100, oc_clear_level: 16'd500,
          uv_trip_level: cfq_pkg::LEVEL_MAX, uv_clear_level: cfq_pkg::LEVEL_MIN,
          ov_trip_level: cfq_pkg::LEVEL_MIN, ov_clear_level: cfq_pkg::LEVEL_MAX,
          leak_trip_level: cfq_pkg::LEVEL_MIN, persist_ticks: 16'd0};
    program_all(c);
    send_tick(tick_of(16'd300, cfq_pkg::LEVEL_MAX, 16'd1, 16'h5555, 1'b0));
    send_tick(tick_of(16'd50, 16'hFFFE, cfq_pkg::LEVEL_MIN, 16'hAAAA, 1'b1));
    send_tick(tick_of(cfq_pkg::LEVEL_MAX, cfq_pkg::LEVEL_MIN, cfq_pkg::LEVEL_MAX,
                      16'd0, 1'b0));
    send_tick(tick_of(cfq_pkg::LEVEL_MIN, cfq_pkg::LEVEL_MAX, cfq_pkg::LEVEL_MIN,
                      16'd0, 1'b1));

    // Random traffic under three idle patterns, several settings in each
    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 78 : 0;
      rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 7 : 0;
      for (k = 0; k < 4; k++) begin
        drain_results();
        if (phase == 0 && k == 0) begin
          c = '0;
        end else if (phase == 1 && k == 0) begin
          c = '1;
        end else begin
          c.oc_trip_level   = rand_level();
          c.oc_clear_level  = ($urandom_range(3) != 0)
                              ? pick_between(0, int'(c.oc_trip_level)) : rand_level();
          c.uv_trip_level   = rand_level();
          c.uv_clear_level  = ($urandom_range(3) != 0)
                              ? pick_between(int'(c.uv_trip_level), 65535) : rand_level();
          c.ov_trip_level   = rand_level();
          c.ov_clear_level  = ($urandom_range(3) != 0)
                              ? pick_between(0, int'(c.ov_trip_level)) : rand_level();
          c.leak_trip_level = rand_level();
          case ($urandom_range(5))
            0:       c.persist_ticks = 16'd0;
            1:       c.persist_ticks = 16'($urandom_range(20, 5));
            default: c.persist_ticks = 16'($urandom_range(3, 1));
          endcase
        end
        program_all(c);
        // Hold the receiver off while the sender keeps offering
        if (phase == 2 && k == 1) stall_req = 1'b1;
        send_random_ticks(42);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> charger_fault_qualifier.f
+incdir+design
design/cfq_pkg.sv
design/cfq_cfg.sv
design/cfq_qualifier.sv
design/cfq_debounce.sv
design/charger_fault_qualifier.sv
tb/sv/tb_top.sv
